FILE: design/bqc_pkg.sv
package bqc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = COEF_W + DATA_W;      // one coefficient times one delay value
  localparam int ACC_W    = PROD_W + 2;           // room for three products
  localparam int SHIFT    = 15;                   // Q2.15 scaling
  localparam int SUM_W    = ACC_W - SHIFT + 1;    // x minus shifted feedback
  localparam int SLOTS    = 5;

  localparam logic [1:0] MODE_FILTER = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MS_A1_W1 = 3'd0,
    MS_A2_W2 = 3'd1,
    MS_B0_W  = 3'd2,
    MS_B1_W1 = 3'd3,
    MS_B2_W2 = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load_sample;
    logic     write_coef;
    logic     clear_hist;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     calc_w;
    logic     calc_y;
    logic     load_out;
  } cmd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7FFF_FFFF);
    lo = SUM_W'(32'sh8000_0000);
    if (v > hi) begin
      return DATA_W'(32'h7FFF_FFFF);
    end else if (v < lo) begin
      return DATA_W'(32'h8000_0000);
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [DATA_W-1:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: design/bqc_ctrl.sv
module bqc_ctrl #(
  parameter int NUM_SECTIONS = 4,
  parameter int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      mode,
  input  logic            out_blocked,
  output bqc_pkg::cmd_t   cmd,
  output logic [SEC_W-1:0] sec
);
  import bqc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL_A1 = 9'b000000010,
    ST_MUL_A2 = 9'b000000100,
    ST_CALC_W = 9'b000001000,
    ST_MUL_B0 = 9'b000010000,
    ST_MUL_B1 = 9'b000100000,
    ST_MUL_B2 = 9'b001000000,
    ST_CALC_Y = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [SEC_W-1:0] sec_next;
  logic last_sec;
  logic accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_sec = (sec == SEC_W'(NUM_SECTIONS - 1));

  always_comb begin
    state_next = state;
    sec_next   = sec;
    cmd        = '0;
    cmd.mul_sel = MS_A1_W1;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_FILTER: begin
              cmd.load_sample = 1'b1;
              sec_next        = '0;
              state_next      = ST_MUL_A1;
            end
            MODE_COEF:  cmd.write_coef = 1'b1;
            MODE_CLEAR: cmd.clear_hist = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MUL_A1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_A1_W1;
        state_next  = ST_MUL_A2;
      end
      ST_MUL_A2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_A2_W2;
        cmd.acc_load = 1'b1;
        state_next   = ST_CALC_W;
      end
      ST_CALC_W: begin
        cmd.calc_w = 1'b1;
        state_next = ST_MUL_B0;
      end
      ST_MUL_B0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_B0_W;
        state_next  = ST_MUL_B1;
      end
      ST_MUL_B1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_B1_W1;
        cmd.acc_load = 1'b1;
        state_next   = ST_MUL_B2;
      end
      ST_MUL_B2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_B2_W2;
        cmd.acc_add = 1'b1;
        state_next  = ST_CALC_Y;
      end
      ST_CALC_Y: begin
        cmd.calc_y = 1'b1;
        if (last_sec) begin
          state_next = ST_DONE;
        end else begin
          sec_next   = sec + 1'b1;
          state_next = ST_MUL_A1;
        end
      end
      ST_DONE: begin
        // hold the finished sample until the output register frees up
        if (!out_blocked) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sec   <= '0;
    end else begin
      state <= state_next;
      sec   <= sec_next;
    end
  end

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    sec <= SEC_W'(NUM_SECTIONS - 1))
    else $error("section counter out of range");

  a_filter_start: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_FILTER) |=> (state == ST_MUL_A1 && sec == '0))
    else $error("filter transfer did not start the first section");

  a_other_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && mode != MODE_FILTER) |=> state == ST_IDLE)
    else $error("non-filter transfer left idle");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC_Y && last_sec) |=> state == ST_DONE)
    else $error("last section did not finish");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_blocked)
    else $error("output overwritten while held");

endmodule

FILE: design/bqc_datapath.sv
module bqc_datapath #(
  parameter int NUM_SECTIONS = 4,
  parameter int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bqc_pkg::cmd_t                          cmd,
  input  logic [SEC_W-1:0]                       sec,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]    sample_in,
  input  logic [2:0]                             section_index,
  input  logic [2:0]                             coef_slot,
  input  logic signed [bqc_pkg::COEF_W-1:0]      coef_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bqc_pkg::SAMPLE_W-1:0]    sample_out,
  output logic                                   out_blocked
);
  import bqc_pkg::*;

  logic signed [DATA_W-1:0] delay_one [NUM_SECTIONS];
  logic signed [DATA_W-1:0] delay_two [NUM_SECTIONS];
  logic signed [COEF_W-1:0] coef [NUM_SECTIONS][SLOTS];

  logic signed [DATA_W-1:0]  x;     // section input, then section output
  logic signed [DATA_W-1:0]  w;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [COEF_W-1:0]  coef_op;
  logic signed [DATA_W-1:0]  data_op;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-SHIFT-1:0] sum_shr;
  logic signed [SUM_W-1:0]   w_pre;
  logic coef_ok;

  always_comb begin
    case (cmd.mul_sel)
      MS_A1_W1: begin
        coef_op = coef[sec][SLOT_A1];
        data_op = delay_one[sec];
      end
      MS_A2_W2: begin
        coef_op = coef[sec][SLOT_A2];
        data_op = delay_two[sec];
      end
      MS_B0_W: begin
        coef_op = coef[sec][SLOT_B0];
        data_op = w;
      end
      MS_B1_W1: begin
        coef_op = coef[sec][SLOT_B1];
        data_op = delay_one[sec];
      end
      MS_B2_W2: begin
        coef_op = coef[sec][SLOT_B2];
        data_op = delay_two[sec];
      end
      default: begin
        coef_op = '0;
        data_op = '0;
      end
    endcase
  end

  assign prod_next = coef_op * data_op;
  assign sum       = acc + ACC_W'(prod);
  assign sum_shr   = sum[ACC_W-1:SHIFT];   // arithmetic shift, floors
  assign w_pre     = SUM_W'(x) - SUM_W'(sum_shr);

  assign coef_ok = ({1'b0, section_index} < 4'(NUM_SECTIONS)) && (coef_slot < 3'(SLOTS));

  assign out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_add) begin
      acc <= sum;
    end
    if (cmd.load_sample) begin
      x <= DATA_W'(sample_in);
    end else if (cmd.calc_y) begin
      x <= sat32(SUM_W'(sum_shr));
    end
    if (cmd.calc_w) begin
      w <= sat32(w_pre);
    end
    if (cmd.load_out) begin
      sample_out <= sat16(x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_hist) begin
      for (int s = 0; s < NUM_SECTIONS; s++) begin
        delay_one[s] <= '0;
        delay_two[s] <= '0;
      end
    end else if (cmd.calc_y) begin
      delay_two[sec] <= delay_one[sec];
      delay_one[sec] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SECTIONS; s++) begin
        for (int k = 0; k < SLOTS; k++) begin
          coef[s][k] <= '0;
        end
      end
    end else if (cmd.write_coef && coef_ok) begin
      coef[section_index[SEC_W-1:0]][coef_slot] <= coef_value;
    end
  end

endmodule

FILE: design/biquad_cascade_iir_filter.sv
// Cascade of direct-form-II biquad sections for 16-bit audio.
// Input channel: in_valid/in_stall with mode, sample_in, section_index,
// coef_slot, coef_value. Mode 0 filters sample_in through every section,
// mode 1 writes one Q2.15 coefficient (out-of-range section or slot is
// ignored), mode 2 clears the history of all sections, mode 3 is ignored.
// Output channel: out_valid/out_stall with sample_out, one transfer per
// mode 0 item, saturated to 16 bits.
// One shared 18x32 multiplier handles the five products of each section
// in sequence: a1 and a2, a step forming w, b0, b1 and b2, a step forming
// y. A filter item is taken in idle; after the last section its result is
// loaded into the output register and the block returns to idle, where
// the next item can be taken. Coefficient and clear items are handled in
// idle without leaving it. in_stall is high whenever a sample is in flight.
// A finished result sits in the output register while the next item is
// taken; if a second result completes while the first is still stalled,
// the block waits with in_stall high until the output register drains.
// Synchronous reset clears all coefficients and history and empties the
// output register.
module biquad_cascade_iir_filter #(
  parameter int NUM_SECTIONS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [2:0]                          section_index,
  input  logic [2:0]                          coef_slot,
  input  logic signed [bqc_pkg::COEF_W-1:0]   coef_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out
);
  import bqc_pkg::*;

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

  cmd_t             cmd;
  logic [SEC_W-1:0] sec;
  logic             out_blocked;

  bqc_ctrl #(
    .NUM_SECTIONS(NUM_SECTIONS),
    .SEC_W(SEC_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .out_blocked(out_blocked),
    .cmd(cmd),
    .sec(sec)
  );

  bqc_datapath #(
    .NUM_SECTIONS(NUM_SECTIONS),
    .SEC_W(SEC_W)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sec(sec),
    .sample_in(sample_in),
    .section_index(section_index),
    .coef_slot(coef_slot),
    .coef_value(coef_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .out_blocked(out_blocked)
  );

endmodule

FILE: test/biquad_cascade_iir_filter_tb.sv
module biquad_cascade_iir_filter_tb;
  import bqc_pkg::*;

  localparam int NSEC = 4;
  localparam int ITEMS = 1200;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 7 * NSEC + 12;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint I32_MAX = 2147483647;
  localparam longint I32_MIN = -I32_MAX - 1;

  typedef struct {
    logic [1:0]                op;
    logic signed [SAMPLE_W-1:0] smp;
    logic [2:0]                sec;
    logic [2:0]                slot;
    logic signed [COEF_W-1:0]  coef;
    bit                        typed;
    logic signed [SAMPLE_W-1:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_FILTER;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic [2:0] section_index = '0;
  logic [2:0] coef_slot = '0;
  logic signed [COEF_W-1:0] coef_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;

  // typed expectation riding along with the current directed row
  bit row_typed = 1'b0;
  logic signed [SAMPLE_W-1:0] row_want = '0;

  // predictor state
  logic signed [COEF_W-1:0] coef_bank [NSEC][SLOTS];
  logic signed [DATA_W-1:0] hist_w1 [NSEC];
  logic signed [DATA_W-1:0] hist_w2 [NSEC];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  stim_row_t dir_rows [$];
  int errors = 0;
  int idle_cycles = 0;
  int samples_done = 0, coefs_done = 0, clears_done = 0, ignored_done = 0;
  int results_seen = 0, rail_hits = 0;
  int burst_left = 0;
  int stall_pct = 0, stall_len = 0;

  biquad_cascade_iir_filter #(.NUM_SECTIONS(NSEC)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .sample_in(sample_in), .section_index(section_index),
    .coef_slot(coef_slot), .coef_value(coef_value),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out)
  );

  always #4 clk = ~clk;

  function automatic longint clip32(input longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  // runs one sample through every section and advances the history
  function automatic logic signed [SAMPLE_W-1:0] filter_cascade(
      input logic signed [SAMPLE_W-1:0] x_in);
    longint x, w1, w2, fb, w, acc;
    longint c [SLOTS];
    int s, k;
    x = x_in;
    for (s = 0; s < NSEC; s++) begin
      for (k = 0; k < SLOTS; k++) c[k] = coef_bank[s][k];
      w1 = hist_w1[s];
      w2 = hist_w2[s];
      fb = c[SLOT_A1] * w1 + c[SLOT_A2] * w2;
      w = clip32(x - (fb >>> SHIFT));
      acc = c[SLOT_B0] * w + c[SLOT_B1] * w1 + c[SLOT_B2] * w2;
      x = clip32(acc >>> SHIFT);
      hist_w2[s] = w1[DATA_W-1:0];
      hist_w1[s] = w[DATA_W-1:0];
    end
    if (x > 32767) x = 32767;
    else if (x < -32768) x = -32768;
    return x[SAMPLE_W-1:0];
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(rand_between(-300, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // transfer monitor: prediction, checking and watchdog
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] y;
    bit moved;
    if (rst) begin
      for (int s = 0; s < NSEC; s++) begin
        hist_w1[s] = '0;
        hist_w2[s] = '0;
        for (int k = 0; k < SLOTS; k++) coef_bank[s][k] = '0;
      end
    end else begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        case (mode)
          MODE_FILTER: begin
            y = filter_cascade(sample_in);
            expected_samples.push_back(row_typed ? row_want : y);
            samples_done++;
          end
          MODE_COEF: begin
            if (section_index < NSEC && coef_slot < SLOTS) begin
              coef_bank[section_index][coef_slot] = coef_value;
              coefs_done++;
            end else begin
              ignored_done++;
            end
          end
          MODE_CLEAR: begin
            for (int s = 0; s < NSEC; s++) begin
              hist_w1[s] = '0;
              hist_w2[s] = '0;
            end
            clears_done++;
          end
          default: ignored_done++;
        endcase
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        if (sample_out == 16'sh7FFF || sample_out == 16'sh8000) rail_hits++;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample_out transfer, expected none, got %0d",
                   $time, sample_out);
          errors++;
        end else begin
          y = expected_samples.pop_front();
          if (sample_out !== y) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, y, sample_out);
            errors++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("biquad_cascade_iir_filter_tb failed");
        $finish;
      end
    end
  end

  // receiver: stall probability changes from window to window
  always @(posedge clk) begin
    if (stall_len == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stall_len = rand_between(20, 150);
    end else begin
      stall_len--;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic push_item(input logic [1:0] op, input logic signed [SAMPLE_W-1:0] smp,
                           input logic [2:0] sec, input logic [2:0] slot,
                           input logic signed [COEF_W-1:0] cv,
                           input bit typed = 1'b0,
                           input logic signed [SAMPLE_W-1:0] want = '0);
    int gap;
    in_valid <= 1'b1;
    mode <= op;
    sample_in <= smp;
    section_index <= sec;
    coef_slot <= slot;
    coef_value <= cv;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      case ($urandom_range(0, 5))
        0, 1, 2: gap = 0;
        3, 4: gap = rand_between(1, 8);
        default: gap = rand_between(9, 40);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic add_row(input logic [1:0] op, input int smp, input int sec, input int slot,
                         input int cv, input bit typed = 1'b0, input int want = 0);
    stim_row_t r;
    r.op = op;
    r.smp = smp[SAMPLE_W-1:0];
    r.sec = sec[2:0];
    r.slot = slot[2:0];
    r.coef = cv[COEF_W-1:0];
    r.typed = typed;
    r.want = want[SAMPLE_W-1:0];
    dir_rows.push_back(r);
  endtask

  initial begin
    int live_items;
    int n, s, k, profile;
    logic signed [COEF_W-1:0] cv;

    // zero coefficients after reset give silence
    add_row(MODE_FILTER, 32767, 0, 0, 0, 1, 0);
    add_row(MODE_FILTER, -32768, 0, 0, 0, 1, 0);
    add_row(MODE_SPARE, 1234, 0, SLOT_B0, 32768);
    // unity pass-through on every section
    for (s = 0; s < NSEC; s++) add_row(MODE_COEF, 0, s, SLOT_B0, 32768);
    add_row(MODE_FILTER, 32767, 0, 0, 0, 1, 32767);
    add_row(MODE_FILTER, -32768, 0, 0, 0, 1, -32768);
    // writes to a missing section or slot must not land
    add_row(MODE_COEF, 0, 4, SLOT_B0, 0);
    add_row(MODE_COEF, 0, 7, SLOT_B0, -131072);
    add_row(MODE_COEF, 0, 0, 5, 0);
    add_row(MODE_COEF, 0, 0, 7, -131072);
    add_row(MODE_FILTER, 12345, 0, 0, 0, 1, 12345);
    // gain near four drives the output into saturation
    add_row(MODE_COEF, 0, 0, SLOT_B0, 131071);
    add_row(MODE_FILTER, 32767, 0, 0, 0, 1, 32767);
    add_row(MODE_FILTER, -32768, 0, 0, 0, 1, -32768);
    // extreme feedback: history grows until the 32-bit clamp
    add_row(MODE_COEF, 0, 1, SLOT_A1, -131072);
    add_row(MODE_COEF, 0, 1, SLOT_B1, 131071);
    add_row(MODE_COEF, 0, 2, SLOT_B2, -131072);
    add_row(MODE_COEF, 0, 3, SLOT_A2, 131071);
    add_row(MODE_FILTER, 32767, 0, 0, 0);
    add_row(MODE_FILTER, -32768, 0, 0, 0);
    add_row(MODE_FILTER, -1, 0, 0, 0);
    // history clear keeps coefficients; zero in gives zero out
    add_row(MODE_CLEAR, 0, 0, 0, 0);
    add_row(MODE_FILTER, 0, 0, 0, 0, 1, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      push_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].sec, dir_rows[i].slot,
                dir_rows[i].coef, dir_rows[i].typed, dir_rows[i].want);
    wait_all_results();

    live_items = 0;
    while (live_items < ITEMS) begin
      profile = $urandom_range(0, 9);
      if (profile < 6) begin
        // fresh, mostly well-behaved filter on every section
        for (s = 0; s < NSEC; s++)
          for (k = 0; k < SLOTS; k++) begin
            case (3'(k))
              SLOT_A1: cv = 18'(rand_between(-40000, 40000));
              SLOT_A2: cv = 18'(rand_between(-16000, 16000));
              default: cv = 18'(rand_between(-24000, 24000));
            endcase
            push_item(MODE_COEF, 16'($urandom), 3'(s), 3'(k), cv);
            live_items++;
          end
      end else if (profile < 8) begin
        n = rand_between(1, 6);
        repeat (n) begin
          push_item(MODE_COEF, 16'($urandom), 3'($urandom_range(0, NSEC - 1)),
                    3'($urandom_range(0, SLOTS - 1)), 18'($urandom));
          live_items++;
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        push_item(MODE_CLEAR, 16'($urandom), 3'($urandom), 3'($urandom), 18'($urandom));
        live_items++;
      end
      n = rand_between(4, 40);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 2))
            0: push_item(MODE_SPARE, 16'($urandom), 3'($urandom), 3'($urandom),
                         18'($urandom));
            1: push_item(MODE_COEF, 16'($urandom), 3'($urandom_range(NSEC, 7)),
                         3'($urandom), 18'($urandom));
            default: push_item(MODE_COEF, 16'($urandom), 3'($urandom),
                               3'($urandom_range(SLOTS, 7)), 18'($urandom));
          endcase
        end
        push_item(MODE_FILTER, pick_sample(), 3'($urandom), 3'($urandom), 18'($urandom));
        live_items++;
      end
      if ($urandom_range(0, 15) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d coefficient writes, %0d history clears, %0d ignored",
             samples_done, coefs_done, clears_done, ignored_done);
    $display("%0d results checked, %0d of them at the 16-bit rails", results_seen, rail_hits);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("biquad_cascade_iir_filter_tb passed");
    end else begin
      $display("biquad_cascade_iir_filter_tb failed");
    end
    $finish;
  end

endmodule
